// ===== rtl/pur_pkg.sv =====
// ----------------------------------------------------------------------------
// pur_pkg
// Shared constants, types and controller codes for the polyline resampler.
// ----------------------------------------------------------------------------
package pur_pkg;

  localparam int MAX_POINTS  = 256;
  localparam int MAX_SAMPLES = 64;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int POINT_W     = 3 * COORD_W;
  localparam int CFG_W       = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);

  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SAMP_W  = $clog2(MAX_SAMPLES + 1);
  localparam int DEN_W   = $clog2(MAX_SAMPLES + 2);
  localparam int NUM_W   = $clog2(MAX_SAMPLES * (MAX_POINTS - 1) + 1);
  localparam int DIV_W   = NUM_W + FRAC_BITS;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int PROD_W  = COORD_W + FRAC_BITS;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_RD_P,
    ST_RD_N,
    ST_GET_N,
    ST_MUL,
    ST_EMIT
  } pur_state_t;

  typedef struct packed {
    logic load_pt;
    logic start_line;
    logic div_step;
    logic rd_next;
    logic cap_p;
    logic cap_n;
    logic mul;
    logic emit;
    logic next_sample;
  } pur_cmd_t;

  typedef struct packed {
    logic short_line;
    logic zero_samples;
    logic div_last;
    logic final_sample;
    logic out_free;
  } pur_sts_t;

endpackage

// ===== rtl/pur_ram.sv =====
// ----------------------------------------------------------------------------
// pur_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pur_ctrl.sv =====
// ----------------------------------------------------------------------------
// pur_ctrl
// Sequencer: point load, per-sample divide, two point reads, lerp and emit.
// ----------------------------------------------------------------------------
module pur_ctrl
  import pur_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last,
  input  pur_sts_t sts,
  output logic     in_stall,
  output pur_cmd_t cmd
);

  pur_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_pt = 1'b1;
          if (last && !sts.short_line && !sts.zero_samples) begin
            cmd.start_line = 1'b1;
            state_next     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_RD_P;
        end
      end
      ST_RD_P: begin
        state_next = ST_RD_N;
      end
      ST_RD_N: begin
        cmd.rd_next = 1'b1;
        cmd.cap_p   = 1'b1;
        state_next  = ST_GET_N;
      end
      ST_GET_N: begin
        cmd.cap_n  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.final_sample) begin
            state_next = ST_LOAD;
          end else begin
            cmd.next_sample = 1'b1;
            state_next      = ST_DIV;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/pur_dp.sv =====
// ----------------------------------------------------------------------------
// pur_dp
// Datapath: point store, count, restoring divider, lerp and output register.
// ----------------------------------------------------------------------------
module pur_dp
  import pur_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  pur_cmd_t                  cmd,
  output pur_sts_t                  sts,
  input  logic        [COORD_W-1:0] x,
  input  logic        [COORD_W-1:0] y,
  input  logic        [COORD_W-1:0] z,
  input  logic                      last,
  input  logic                      cfg_write,
  input  logic        [CFG_W-1:0]   cfg_data,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] sample_x,
  output logic signed [COORD_W-1:0] sample_y,
  output logic signed [COORD_W-1:0] sample_z,
  output logic                      last_sample
);

  // configuration and line state
  logic [CFG_W-1:0]  samples_per_line;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  n_m1;
  logic [SAMP_W-1:0] s_lat;
  logic [DEN_W-1:0]  den;
  logic [SAMP_W-1:0] idx;
  logic [NUM_W-1:0]  num;

  // divider
  logic [DIV_W-1:0]  dq;
  logic [DEN_W-1:0]  rem;
  logic [DCNT_W-1:0] div_cnt;

  // point pair and products
  logic [POINT_W-1:0] p_pt, n_pt, rdata;
  logic [PROD_W-1:0]  prod_x, prod_y, prod_z;

  logic               has_room;
  logic [CNT_W-1:0]   n_eff;
  logic [SAMP_W-1:0]  s_eff;
  logic [NUM_W-1:0]   num_next;
  logic [DEN_W:0]     rem_sh;
  logic               rem_ge;
  logic [ADDR_W-1:0]  q_addr, nx_addr, raddr;
  logic [FRAC_BITS-1:0] t_frac;

  assign has_room = (count < CNT_W'(MAX_POINTS));
  assign n_eff    = count + CNT_W'(has_room);
  assign s_eff    = (samples_per_line > CFG_W'(MAX_SAMPLES)) ? SAMP_W'(MAX_SAMPLES)
                                                             : SAMP_W'(samples_per_line);

  assign num_next = cmd.start_line ? NUM_W'(n_eff - CNT_W'(1))
                                   : NUM_W'(num + NUM_W'(n_m1));

  assign rem_sh = {rem, dq[DIV_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den});

  assign q_addr  = dq[FRAC_BITS +: ADDR_W];
  assign t_frac  = dq[FRAC_BITS-1:0];
  assign nx_addr = q_addr + ADDR_W'(t_frac != '0);
  assign raddr   = cmd.rd_next ? nx_addr : q_addr;

  assign sts.short_line   = (n_eff < CNT_W'(2));
  assign sts.zero_samples = (samples_per_line == '0);
  assign sts.div_last     = (div_cnt == DCNT_W'(DIV_W - 1));
  assign sts.final_sample = (idx == s_lat);
  assign sts.out_free     = !out_valid || !out_stall;

  pur_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_pt && has_room),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({x, y, z}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_line <= CFG_RESET;
      count            <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        samples_per_line <= cfg_data;
      end
      if (cmd.load_pt) begin
        count <= last ? '0 : n_eff;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start_line) begin
      n_m1  <= n_eff - CNT_W'(1);
      s_lat <= s_eff;
      den   <= DEN_W'(s_eff) + DEN_W'(1);
      idx   <= SAMP_W'(1);
    end else if (cmd.next_sample) begin
      idx <= idx + SAMP_W'(1);
    end

    if (cmd.start_line || cmd.next_sample) begin
      num     <= num_next;
      dq      <= {num_next, {FRAC_BITS{1'b0}}};
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      dq      <= {dq[DIV_W-2:0], rem_ge};
      div_cnt <= div_cnt + DCNT_W'(1);
    end

    if (cmd.cap_p) begin
      p_pt <= rdata;
    end
    if (cmd.cap_n) begin
      n_pt <= rdata;
    end

    if (cmd.mul) begin
      prod_x <= PROD_W'($signed({1'b0, t_frac}) *
                        ($signed({n_pt[3*COORD_W-1], n_pt[3*COORD_W-1:2*COORD_W]}) -
                         $signed({p_pt[3*COORD_W-1], p_pt[3*COORD_W-1:2*COORD_W]})));
      prod_y <= PROD_W'($signed({1'b0, t_frac}) *
                        ($signed({n_pt[2*COORD_W-1], n_pt[2*COORD_W-1:COORD_W]}) -
                         $signed({p_pt[2*COORD_W-1], p_pt[2*COORD_W-1:COORD_W]})));
      prod_z <= PROD_W'($signed({1'b0, t_frac}) *
                        ($signed({n_pt[COORD_W-1], n_pt[COORD_W-1:0]}) -
                         $signed({p_pt[COORD_W-1], p_pt[COORD_W-1:0]})));
    end

    if (cmd.emit) begin
      sample_x    <= p_pt[3*COORD_W-1:2*COORD_W] + prod_x[FRAC_BITS +: COORD_W];
      sample_y    <= p_pt[2*COORD_W-1:COORD_W]   + prod_y[FRAC_BITS +: COORD_W];
      sample_z    <= p_pt[COORD_W-1:0]           + prod_z[FRAC_BITS +: COORD_W];
      last_sample <= sts.final_sample;
    end
  end

endmodule

// ===== rtl/polyline_uniform_resampler.sv =====
// After the last point of a polyline is accepted, the first sample passes the
//   divider, the two point reads, the multiply and the output register.
// Throughput: one point per cycle while loading; samples one at a time, each
//   waiting on the bit-serial divider (one quotient bit a cycle).
// Reset (rst, synchronous): point count cleared, samples_per_line set to 10,
//   output empty, controller back to loading. Point store is not cleared.
// ----------------------------------------------------------------------------
// polyline_uniform_resampler
// Stores the points of one polyline, then emits samples_per_line samples
// (at most MAX_SAMPLES), spread evenly by index, linearly interpolated between stored points.
// ----------------------------------------------------------------------------
module polyline_uniform_resampler
  import pur_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // point input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic        [COORD_W-1:0] x,
  input  logic        [COORD_W-1:0] y,
  input  logic        [COORD_W-1:0] z,
  input  logic                      last,
  // sample output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] sample_x,
  output logic signed [COORD_W-1:0] sample_y,
  output logic signed [COORD_W-1:0] sample_z,
  output logic                      last_sample,
  // configuration
  input  logic                      cfg_write,
  input  logic        [CFG_W-1:0]   cfg_data
);

  // The controller takes points only in its load state. On the last point
  // it checks the line length and sample count, then steps each sample
  // through: divide i*(n-1) by s+1 into index and fraction, read the two
  // neighbor points, multiply the differences, and emit into the output
  // register. That register parts the two sides, so loading of the next
  // polyline starts while the final sample still waits to be taken.
  pur_cmd_t cmd;
  pur_sts_t sts;

  pur_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pur_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .x           (x),
    .y           (y),
    .z           (z),
    .last        (last),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .sample_z    (sample_z),
    .last_sample (last_sample)
  );

  // Never overwrite a result that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("sample emitted over a pending result");

  // After the final sample the block loads again in the next cycle.
  a_final_reload: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.final_sample) |=> !in_stall)
    else $error("block not loading after final sample");

  // A sample run starts only on an accepted last point.
  a_start_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.start_line |-> (cmd.load_pt && last && in_valid))
    else $error("sample run started without a last point");

  // The final flag goes out exactly with a fresh result.
  a_last_with_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.final_sample) |=> (out_valid && last_sample))
    else $error("final sample flag lost");

endmodule

// ===== tb/sv/polyline_uniform_resampler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_uniform_resampler_tb
// Self-checking bench for the polyline resampler. Points go in as beats on
// the input channel, a behavioral copy of the resampler predicts every
// interpolated sample, and each sample beat is compared field by field with
// the oldest prediction. A short directed table covers coordinate extremes,
// short lines, zero and saturated sample counts and exact hits. Random
// polylines with random sample counts, store overflow, random idling and a
// long output hold-off follow.
// ----------------------------------------------------------------------------
module polyline_uniform_resampler_tb;
  import pur_pkg::*;

  localparam int    HALF_PERIOD      = 4;
  localparam int    RESET_CYCLES     = 7;
  localparam int    RANDOM_POINTS    = 390;
  // settle time after draining, padded so a first sample can still show up
  localparam int    SETTLE_CYCLES    = 48;
  localparam int    LONG_HOLD_CYCLES = 500;
  localparam int    HOLD_LINE        = 12;
  localparam int    DRAIN_LINE       = 20;
  localparam int    MAX_REPORTS      = 10;
  localparam longint TIMEOUT_NS      = 80_000_000;

  typedef logic [COORD_W-1:0] coord_t;

  // one interpolated sample as it leaves the block
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t sz;
    logic   fin;
  } sample_t;

  // one row of the directed table: optional register write, then a point
  typedef struct packed {
    logic             set_cfg;
    logic [CFG_W-1:0] cfg;
    coord_t           px;
    coord_t           py;
    coord_t           pz;
    logic             fin;
    logic             typed;
    coord_t           ex;
    coord_t           ey;
    coord_t           ez;
  } step_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  coord_t           x = '0;
  coord_t           y = '0;
  coord_t           z = '0;
  logic             last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic signed [COORD_W-1:0] sample_x;
  logic signed [COORD_W-1:0] sample_y;
  logic signed [COORD_W-1:0] sample_z;
  logic             last_sample;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state: stored points, their count and the sample count register
  coord_t           line_x [MAX_POINTS];
  coord_t           line_y [MAX_POINTS];
  coord_t           line_z [MAX_POINTS];
  int unsigned      stored_points;
  logic [CFG_W-1:0] samples_setting;

  sample_t          pending_samples [$];

  int mismatches      = 0;
  int samples_checked = 0;
  int points_sent     = 0;
  int lines_sent      = 0;
  int cfg_writes      = 0;
  int hold_requests   = 0;
  int holds_served    = 0;
  bit tx_calm         = 1'b0;

  polyline_uniform_resampler uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x           (x),
    .y           (y),
    .z           (z),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .sample_z    (sample_z),
    .last_sample (last_sample),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // p + floor(t * (q - p) / 2^16); an arithmetic shift gives the floor
  function automatic coord_t blend_coord(coord_t p, coord_t q, int unsigned t);
    longint ps;
    longint qs;
    longint prod;
    ps   = {{32{p[COORD_W-1]}}, p};
    qs   = {{32{q[COORD_W-1]}}, q};
    prod = longint'(t) * (qs - ps);
    return coord_t'(ps + (prod >>> FRAC_BITS));
  endfunction

  // Store one accepted point; on the closing point queue every sample it causes.
  task automatic resample_point(coord_t px, coord_t py, coord_t pz, logic pf);
    int unsigned n;
    int unsigned s;
    int unsigned den;
    int unsigned num;
    int unsigned q;
    int unsigned r;
    int unsigned t;
    int unsigned nx;
    sample_t     smp;
    // a full store drops the point but still honors its last flag
    if (stored_points < MAX_POINTS) begin
      line_x[stored_points] = px;
      line_y[stored_points] = py;
      line_z[stored_points] = pz;
      stored_points++;
    end
    if (!pf) return;
    n             = stored_points;
    stored_points = 0;
    if (n < 2) return;
    s   = (samples_setting > MAX_SAMPLES) ? MAX_SAMPLES : samples_setting;
    den = s + 1;
    for (int unsigned i = 1; i <= s; i++) begin
      num = i * (n - 1);
      q   = num / den;
      r   = num % den;
      t   = (r << FRAC_BITS) / den;
      nx  = (r != 0) ? q + 1 : q;
      if (q >= n) q = n - 1;
      if (nx >= n) nx = n - 1;
      smp.sx  = blend_coord(line_x[q], line_x[nx], t);
      smp.sy  = blend_coord(line_y[q], line_y[nx], t);
      smp.sz  = blend_coord(line_z[q], line_z[nx], t);
      smp.fin = (i == s);
      pending_samples = {pending_samples, smp};
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Offer one point beat, hold it while stalled, predict once accepted.
  // Called at a clock edge; returns at the edge that took the beat.
  task automatic offer_point(coord_t px, coord_t py, coord_t pz, logic pf);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x        <= px;
    y        <= py;
    z        <= pz;
    last     <= pf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
    if (pf) lines_sent++;
    resample_point(px, py, pz, pf);
  endtask

  // Stop offering until every predicted sample has left the block, then let
  // it settle in case the last line produced nothing.
  task automatic wait_samples_drained();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the sample count register while the block is idle.
  task automatic write_samples_setting(logic [CFG_W-1:0] value);
    wait_samples_drained();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write       <= 1'b0;
    samples_setting = value;
    cfg_writes++;
  endtask

  // Sample counts: mostly small, with zero, one, the maximum and
  // out-of-range values that saturate.
  function automatic logic [CFG_W-1:0] pick_samples();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 16) return CFG_W'(1);
    if (r < 24) return CFG_W'(MAX_SAMPLES);
    if (r < 30) return CFG_W'($urandom_range(MAX_SAMPLES + 1, 127));
    return CFG_W'($urandom_range(2, 16));
  endfunction

  // Narrow coordinates keep neighbors close; wide ones hit every bit.
  function automatic coord_t pick_coord(bit narrow);
    if (narrow) return coord_t'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    return coord_t'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stall, long hold-off on request, check every beat
  // --------------------------------------------------------------------------
  initial begin
    int      stall_left;
    int      hold_left;
    int      rx_cycle;
    bit      rx_calm;
    int      r;
    sample_t got;
    sample_t want;
    stall_left = 0;
    hold_left  = 0;
    rx_cycle   = 0;
    rx_calm    = 1'b0;
    forever begin
      @(posedge clk);
      // check the beat taken at this edge against the oldest prediction
      if (!rst && out_valid && !out_stall) begin
        got = '{sample_x, sample_y, sample_z, last_sample};
        samples_checked++;
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected sample x=%h y=%h z=%h last=%b",
                     $realtime, got.sx, got.sy, got.sz, got.fin);
        end else begin
          want = pending_samples.pop_front();
          if (got.sx !== want.sx || got.sy !== want.sy ||
              got.sz !== want.sz || got.fin !== want.fin) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] mismatch: exp x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                       $realtime, want.sx, want.sy, want.sz, want.fin,
                       got.sx, got.sy, got.sz, got.fin);
          end
        end
      end
      // periodically choose a calm stretch (one chance in four) or a busy one
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      // a requested hold-off wins over everything else
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!rx_calm) begin
          r = $urandom_range(0, 99);
          if (r >= 95)      stall_left = $urandom_range(15, 40);
          else if (r >= 70) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    step_row_t plan [19];
    int        rand_points;
    int        line_no;
    int        len;
    bit        overflow_done;
    bit        narrow;
    sample_t   typed_smp;

    stored_points   = 0;
    samples_setting = CFG_RESET;

    // Directed rows. Typed results only where they read straight off:
    // midpoint of the two coordinate extremes is -1, and an exact hit
    // returns the middle point untouched.
    plan = '{
      // two-point line at the reset sample count
      '{1'b0, 7'd0,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h000B_0000, 32'hFFF5_0000, 32'h7FFF_FFFF, 1'b1,
        1'b0, 32'h0, 32'h0, 32'h0},
      // lone point: too short, nothing comes out
      '{1'b0, 7'd0,   32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
        1'b0, 32'h0, 32'h0, 32'h0},
      // one sample halfway between the most negative and most positive
      '{1'b1, 7'd1,   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
        1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      // three points, one sample: lands exactly on the middle point
      '{1'b0, 7'd0,   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'hFFFF_0000, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1,
        1'b1, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF},
      // zero samples: a complete line, no output
      '{1'b1, 7'd0,   32'hDEAD_BEEF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h0000_0000, 32'hDEAD_BEEF, 32'h8000_0000, 1'b1,
        1'b0, 32'h0, 32'h0, 32'h0},
      // all-ones register saturates to the maximum sample count
      '{1'b1, 7'd127, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
        1'b0, 32'h0, 32'h0, 32'h0},
      // maximum sample count over three points with mixed signs
      '{1'b1, 7'd64,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_8000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_8000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 1'b1,
        1'b0, 32'h0, 32'h0, 32'h0},
      // short line again, then two samples over three points
      '{1'b1, 7'd2,   32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0000, 1'b1,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 1'b0,
        1'b0, 32'h0, 32'h0, 32'h0},
      '{1'b0, 7'd0,   32'h0009_0000, 32'h0006_0000, 32'hFFFF_FFFF, 1'b1,
        1'b0, 32'h0, 32'h0, 32'h0}
    };

    // hold reset, release it on an edge
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    for (int k = 0; k < $size(plan); k++) begin
      if (plan[k].set_cfg) write_samples_setting(plan[k].cfg);
      offer_point(plan[k].px, plan[k].py, plan[k].pz, plan[k].fin);
      if (plan[k].typed) begin
        // replace the single predicted sample with the hand-written one
        typed_smp = '{plan[k].ex, plan[k].ey, plan[k].ez, 1'b1};
        pending_samples[pending_samples.size() - 1] = typed_smp;
      end
    end

    // random polylines
    rand_points   = 0;
    line_no       = 0;
    overflow_done = 1'b0;
    write_samples_setting(CFG_W'($urandom_range(3, 12)));
    while (rand_points < RANDOM_POINTS) begin
      if ($urandom_range(0, 6) == 0) write_samples_setting(pick_samples());
      // once, wait for the output to empty before going on
      if (line_no == DRAIN_LINE) wait_samples_drained();
      tx_calm = ($urandom_range(0, 4) == 0);
      // once, hold the output off and keep offering back to back so the
      // block backs up into its input
      if (line_no == HOLD_LINE) begin
        hold_requests <= hold_requests + 1;
        tx_calm = 1'b1;
      end
      if (line_no == HOLD_LINE + 1) tx_calm = 1'b1;
      // line length: mostly a handful, a few lone points, some longer,
      // and one line that overruns the store
      if (!overflow_done && rand_points >= 120) begin
        len           = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 6);
        overflow_done = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0:       len = 1;
          1, 2:    len = $urandom_range(9, 40);
          default: len = $urandom_range(2, 8);
        endcase
      end
      narrow = $urandom_range(0, 1);
      for (int p = 0; p < len; p++) begin
        offer_point(pick_coord(narrow), pick_coord(narrow), pick_coord(narrow),
                    p == len - 1);
        if (p < MAX_POINTS) rand_points++;
      end
      line_no++;
    end

    // drain, then allow the block's latency before closing out
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_samples.size() != 0) begin
      mismatches += pending_samples.size();
      $display("%0d predicted samples never arrived", pending_samples.size());
    end

    $display("Covered %0d points in %0d polylines and compared %0d samples",
             points_sent, lines_sent, samples_checked);
    $display("over %0d sample-count writes, one store overrun and one long output hold",
             cfg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // end the run if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pur_pkg.sv
rtl/pur_ram.sv
rtl/pur_ctrl.sv
rtl/pur_dp.sv
rtl/polyline_uniform_resampler.sv
tb/sv/polyline_uniform_resampler_tb.sv
